FILE: hw/rtl/differential_psk_demod_pll_assert.svh
// Assertion macros for the differential PSK demodulator.
`ifndef DIFFERENTIAL_PSK_DEMOD_PLL_ASSERT_SVH
`define DIFFERENTIAL_PSK_DEMOD_PLL_ASSERT_SVH
`ifndef SYNTHESIS
`define DPD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DPD_ASSERT_IMPL(label, ante, cons, msg)
`define DPD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/dpd_pkg.sv
// Shared types and constants for the differential PSK demodulator.
package dpd_pkg;
	localparam int SAMPLE_W_DEF = 16;
	localparam int ANGLE_W_DEF  = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W       = 5;
	localparam int GUARD        = 16;
	localparam int INV_GAIN     = 39797;

	localparam logic [2:0] REG_MOD   = 3'd0;
	localparam logic [2:0] REG_ALPHA = 3'd1;
	localparam logic [2:0] REG_BETA  = 3'd2;
	localparam logic [2:0] REG_FUP   = 3'd3;
	localparam logic [2:0] REG_FLO   = 3'd4;

	typedef struct packed {
		logic load;
		logic rot_step;
		logic rot_done;
		logic mix;
		logic vec_init;
		logic vec_step;
		logic gain;
		logic update;
	} cmd_t;

	function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] k);
		logic [31:0] r;
		case (k)
			5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
			5'd20: r = 32'd652;       5'd21: r = 32'd326;
			5'd22: r = 32'd163;       5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage

FILE: hw/rtl/dpd_ctrl.sv
// Sequencer for the demodulator: rotation, mixing, vectoring and loop update.
module dpd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_free,
	output logic busy,
	output logic out_load,
	output logic [dpd_pkg::STEP_W-1:0] step,
	output dpd_pkg::cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ROT  = 3'd1;
	localparam logic [2:0] S_MIX  = 3'd2;
	localparam logic [2:0] S_VEC  = 3'd3;
	localparam logic [2:0] S_GAIN = 3'd4;
	localparam logic [2:0] S_UPD  = 3'd5;
	localparam logic [2:0] S_INIT = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q;
	logic [dpd_pkg::STEP_W-1:0] cnt_q;
	logic last;

	assign last = (cnt_q == dpd_pkg::STEP_W'(dpd_pkg::CORDIC_STEPS - 1));
	assign step = cnt_q;
	assign busy = (state_q != S_IDLE);
	assign out_load = (state_q == S_UPD) && out_free;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		unique case (state_q)
			S_IDLE: ;
			S_ROT: cmd.rot_step = 1'b1;
			S_FIN: cmd.rot_done = 1'b1;
			S_MIX: cmd.mix = 1'b1;
			S_INIT: cmd.vec_init = 1'b1;
			S_VEC: cmd.vec_step = 1'b1;
			S_GAIN: cmd.gain = 1'b1;
			S_UPD: cmd.update = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					state_q <= S_ROT;
					cnt_q <= '0;
				end
				S_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) state_q <= S_FIN;
				end
				S_FIN: state_q <= S_MIX;
				S_MIX: state_q <= S_INIT;
				S_INIT: begin
					state_q <= S_VEC;
					cnt_q <= '0;
				end
				S_VEC: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) state_q <= S_GAIN;
				end
				S_GAIN: state_q <= S_UPD;
				S_UPD: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hw/rtl/dpd_datapath.sv
// Datapath: CORDIC rotator and vectorer, slicer, mixer and loop filter.
module dpd_datapath #(
	parameter int SAMPLE_WIDTH = dpd_pkg::SAMPLE_W_DEF,
	parameter int ANGLE_WIDTH  = dpd_pkg::ANGLE_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  dpd_pkg::cmd_t cmd,
	input  logic [dpd_pkg::STEP_W-1:0] step,
	input  logic signed [SAMPLE_WIDTH-1:0] in_i,
	input  logic signed [SAMPLE_WIDTH-1:0] in_q,
	input  logic modulation,
	input  logic [15:0] alpha_gain,
	input  logic [15:0] beta_gain,
	input  logic signed [15:0] freq_upper,
	input  logic signed [15:0] freq_lower,
	output logic [1:0] symbol
);
	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = ANGLE_WIDTH;
	localparam int CW = SW + dpd_pkg::GUARD + 3;
	localparam int PW = 2 * SW + 2;
	localparam int VW = PW + dpd_pkg::GUARD + 3;
	localparam int MW = CW + 17;
	localparam int GW = AW + 18;
	localparam int FW = AW + 3;
	localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [FW-1:0] FMAX = FW'(2 ** (AW - 1) - 1);
	localparam logic signed [FW-1:0] FMIN = FW'(-(2 ** (AW - 1)));

	logic signed [CW-1:0] ra_q, rb_q;
	logic signed [31:0] rz_q;
	logic signed [SW-1:0] ci_q, cq_q, pi_q, pq_q;
	logic signed [VW-1:0] vx_q, vy_q;
	logic signed [31:0] vz_q;
	logic signed [PW-1:0] er_q, ei_q;
	logic [1:0] sym_q;
	logic [AW-1:0] phase_q;
	logic signed [AW-1:0] freq_q;
	logic signed [GW-1:0] bterm_q, aterm_q;

	function automatic logic signed [SW-1:0] finish(input logic signed [CW-1:0] v);
		logic signed [MW-1:0] m;
		logic signed [MW-1:0] r;
		m = MW'(v) * MW'($signed({1'b0, 16'(dpd_pkg::INV_GAIN)}));
		r = (m + (MW'(1) <<< 31)) >>> 32;
		if (r > MW'(SMAX)) return SMAX;
		if (r < MW'(SMIN)) return SMIN;
		return r[SW-1:0];
	endfunction

	// quarter-turn prerotation
	logic [31:0] z32;
	logic [1:0] quad;
	logic signed [SW+1:0] xa, xb;
	always_comb begin
		z32 = 32'(phase_q) << (32 - AW);
		quad = 2'((z32 + 32'h2000_0000) >> 30);
		xa = (SW+2)'(in_i);
		xb = (SW+2)'(in_q);
		case (quad)
			2'd1: begin xa = -(SW+2)'(in_q); xb = (SW+2)'(in_i); end
			2'd2: begin xa = -(SW+2)'(in_i); xb = -(SW+2)'(in_q); end
			2'd3: begin xa = (SW+2)'(in_q); xb = -(SW+2)'(in_i); end
			default: ;
		endcase
	end

	// product with conjugate of previous, and slicer
	logic signed [PW-1:0] dr, di;
	logic [1:0] sym_d;
	logic signed [PW-1:0] er_d, ei_d;
	always_comb begin
		dr = PW'(ci_q) * PW'(pi_q) + PW'(cq_q) * PW'(pq_q);
		di = PW'(cq_q) * PW'(pi_q) - PW'(ci_q) * PW'(pq_q);
		if (!modulation) begin
			if (dr > 0) begin sym_d = 2'd0; er_d = dr; ei_d = di; end
			else begin sym_d = 2'd1; er_d = -dr; ei_d = -di; end
		end else if (dr < di) begin
			if (dr < -di) begin sym_d = 2'd3; er_d = -dr; ei_d = -di; end
			else begin sym_d = 2'd2; er_d = di; ei_d = -dr; end
		end else begin
			if (dr < -di) begin sym_d = 2'd1; er_d = -di; ei_d = dr; end
			else begin sym_d = 2'd0; er_d = dr; ei_d = di; end
		end
	end

	logic signed [31:0] atk;
	logic signed [31:0] negz;
	logic signed [32:0] eround;
	logic signed [FW-1:0] fnew, pnew, fclamp;
	assign atk = $signed(dpd_pkg::atan_at(step));
	assign negz = -vz_q;
	assign eround = (33'(negz) + (33'sd1 <<< (31 - AW))) >>> (32 - AW);

	always_comb begin
		fnew = FW'(freq_q) + FW'((bterm_q + GW'(32768)) >>> 16);
		pnew = FW'($signed({1'b0, phase_q})) + fnew + FW'((aterm_q + GW'(32768)) >>> 16);
		if (fnew > FW'(freq_upper)) fclamp = FW'(freq_upper);
		else if (fnew < FW'(freq_lower)) fclamp = FW'(freq_lower);
		else fclamp = fnew;
		if (fclamp > FMAX) fclamp = FMAX;
		else if (fclamp < FMIN) fclamp = FMIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pi_q <= SMAX;
			pq_q <= '0;
			phase_q <= '0;
			freq_q <= '0;
		end else begin
			if (cmd.mix) begin
				pi_q <= ci_q;
				pq_q <= cq_q;
			end
			if (cmd.update) begin
				phase_q <= pnew[AW-1:0];
				freq_q <= fclamp[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ra_q <= CW'(xa) <<< dpd_pkg::GUARD;
			rb_q <= CW'(xb) <<< dpd_pkg::GUARD;
			rz_q <= $signed(z32 - {quad, 30'd0});
		end
		if (cmd.rot_step) begin
			if (rz_q >= 0) begin
				ra_q <= ra_q - (rb_q >>> step);
				rb_q <= rb_q + (ra_q >>> step);
				rz_q <= rz_q - atk;
			end else begin
				ra_q <= ra_q + (rb_q >>> step);
				rb_q <= rb_q - (ra_q >>> step);
				rz_q <= rz_q + atk;
			end
		end
		if (cmd.rot_done) begin
			ci_q <= finish(ra_q);
			cq_q <= finish(rb_q);
		end
		if (cmd.mix) begin
			sym_q <= sym_d;
			er_q <= er_d;
			ei_q <= ei_d;
		end
		if (cmd.vec_init) begin
			if (er_q < 0) begin
				vx_q <= VW'(-er_q) <<< dpd_pkg::GUARD;
				vy_q <= VW'(-ei_q) <<< dpd_pkg::GUARD;
				vz_q <= 32'sh8000_0000;
			end else begin
				vx_q <= VW'(er_q) <<< dpd_pkg::GUARD;
				vy_q <= VW'(ei_q) <<< dpd_pkg::GUARD;
				vz_q <= '0;
			end
		end
		if (cmd.vec_step) begin
			if (vx_q == 0 && vy_q == 0) begin
				vz_q <= '0;
			end else if (vy_q > 0) begin
				vx_q <= vx_q + (vy_q >>> step);
				vy_q <= vy_q - (vx_q >>> step);
				vz_q <= vz_q + atk;
			end else begin
				vx_q <= vx_q - (vy_q >>> step);
				vy_q <= vy_q + (vx_q >>> step);
				vz_q <= vz_q - atk;
			end
		end
		if (cmd.gain) begin
			bterm_q <= GW'($signed({1'b0, beta_gain})) * GW'($signed(eround[AW-1:0]));
			aterm_q <= GW'($signed({1'b0, alpha_gain})) * GW'($signed(eround[AW-1:0]));
		end
	end

	assign symbol = sym_q;
endmodule

FILE: hw/rtl/differential_psk_demod_pll.sv
// Top level of the differential PSK demodulator with phase-tracking loop.
//  channel | direction | tdata (low bit up)          | handshake
//  s_axis  | in        | sample_i[15:0] sample_q      | tvalid/tready
//  m_axis  | out       | symbol[1:0], zero pad to 8  | tvalid/tready
//  cfg     | in        | index 0..4, 16-bit data     | cfg_we
// The result of an item is loaded after 24 rotation and 24 vectoring CORDIC
// steps on one shared iteration counter, plus finish, mix, vector setup, gain
// and update states; the next item is taken once the block is idle again.
// The loop phase of one item feeds the next rotation, so items run one at a time.
// The output register holds a result while the next item is accepted; the
// loop update waits while that register is still full.
// Reset is asynchronous; no clearing pass.
`include "differential_psk_demod_pll_assert.svh"
module differential_psk_demod_pll #(
	parameter int SAMPLE_WIDTH = dpd_pkg::SAMPLE_W_DEF,
	parameter int ANGLE_WIDTH  = dpd_pkg::ANGLE_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // sample_i, sample_q
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [7:0] m_axis_tdata, // symbol
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);
	logic mod_q;
	logic [15:0] alpha_q, beta_q;
	logic signed [15:0] fup_q, flo_q;
	logic busy, out_load, in_fire, out_free;
	logic [dpd_pkg::STEP_W-1:0] step;
	dpd_pkg::cmd_t cmd;
	logic [1:0] symbol, osym_q;
	logic ovalid_q;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy;
	assign out_free = !ovalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= 1'b0;
			alpha_q <= 16'd2048;
			beta_q <= 16'd64;
			fup_q <= 16'sd4096;
			flo_q <= -16'sd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpd_pkg::REG_MOD: mod_q <= cfg_data[0];
				dpd_pkg::REG_ALPHA: alpha_q <= cfg_data;
				dpd_pkg::REG_BETA: beta_q <= cfg_data;
				dpd_pkg::REG_FUP: fup_q <= cfg_data;
				dpd_pkg::REG_FLO: flo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (out_load) ovalid_q <= 1'b1;
		else if (m_axis_tready) ovalid_q <= 1'b0;
	end
	always_ff @(posedge clk) if (out_load) osym_q <= symbol;

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {6'd0, osym_q};

	dpd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.busy(busy), .out_load(out_load), .step(step), .cmd(cmd)
	);

	dpd_datapath #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .step(step),
		.in_i(s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.in_q(s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.modulation(mod_q), .alpha_gain(alpha_q), .beta_gain(beta_q),
		.freq_upper(fup_q), .freq_lower(flo_q), .symbol(symbol)
	);

	`DPD_ASSERT_IMPL(a_no_accept_busy, busy, !s_axis_tready, "accepted while busy")
	`DPD_ASSERT_NEXT(a_load_sets_valid, out_load, m_axis_tvalid, "result lost")
	`DPD_ASSERT_IMPL(a_load_free, out_load, out_free, "result overwritten")
endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the differential PSK demodulator with phase-tracking loop.
`timescale 1ns / 100ps
module testbench;
	localparam int LIMIT = 1500000;
	localparam int HOLD = 80;
	localparam int NONE = -1;

	typedef struct {
		int si;
		int sq;
		int want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int cycles = 0;
	int errors = 0;
	bit calm = 0;
	logic [1:0] symbols_due[$];

	// predictor state and registers
	bit mod_qpsk;
	longint g_alpha, g_beta, f_hi, f_lo;
	longint last_i, last_q, lp_freq;
	logic [15:0] lp_phase;
	longint arctan[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	differential_psk_demod_pll i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic longint rnd(longint v, int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint wrap32(longint v);
		longint u;
		u = v & 64'hFFFF_FFFF;
		return u[31] ? u - 64'h1_0000_0000 : u;
	endfunction

	function automatic void derotate(inout longint x, inout longint y);
		longint z32, z, a, b, t, da, db;
		int q;
		z32 = longint'(lp_phase) << 16;
		q = int'(((z32 + 64'h2000_0000) >> 30) & 3);
		z = wrap32(z32 - longint'(q) * 64'h4000_0000);
		a = x;
		b = y;
		if (q == 1) begin
			t = a; a = -b; b = t;
		end else if (q == 2) begin
			a = -a; b = -b;
		end else if (q == 3) begin
			t = a; a = b; b = -t;
		end
		a = a <<< dpd_pkg::GUARD;
		b = b <<< dpd_pkg::GUARD;
		for (int k = 0; k < 24; k++) begin
			da = b >>> k;
			db = a >>> k;
			if (z >= 0) begin
				a -= da; b += db; z -= arctan[k];
			end else begin
				a += da; b -= db; z += arctan[k];
			end
		end
		x = sat16(rnd(a * dpd_pkg::INV_GAIN, 32));
		y = sat16(rnd(b * dpd_pkg::INV_GAIN, 32));
	endfunction

	function automatic longint phase_of(longint x, longint y);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			x = -x; y = -y; z = 64'h8000_0000;
		end
		x = x <<< dpd_pkg::GUARD;
		y = y <<< dpd_pkg::GUARD;
		for (int k = 0; k < 24; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (y > 0) begin
				x += dx; y -= dy; z += arctan[k];
			end else begin
				x -= dx; y += dy; z -= arctan[k];
			end
		end
		return wrap32(z);
	endfunction

	function automatic logic [1:0] demod_step(longint si, longint sq);
		longint ci, cq, dr, di, er, ei, e, f, p;
		logic [1:0] sym;
		ci = si;
		cq = sq;
		derotate(ci, cq);
		dr = ci * last_i + cq * last_q;
		di = cq * last_i - ci * last_q;
		if (!mod_qpsk) begin
			if (dr > 0) begin
				sym = 0; er = dr; ei = di;
			end else begin
				sym = 1; er = -dr; ei = -di;
			end
		end else if (dr < di) begin
			if (dr < -di) begin
				sym = 3; er = -dr; ei = -di;
			end else begin
				sym = 2; er = di; ei = -dr;
			end
		end else begin
			if (dr < -di) begin
				sym = 1; er = -di; ei = dr;
			end else begin
				sym = 0; er = dr; ei = di;
			end
		end
		e = rnd(-phase_of(er, ei), 16);
		f = lp_freq + rnd(g_beta * e, 16);
		p = longint'(lp_phase) + f + rnd(g_alpha * e, 16);
		lp_phase = p[15:0];
		if (f > f_hi) f = f_hi;
		else if (f < f_lo) f = f_lo;
		lp_freq = sat16(f);
		last_i = ci;
		last_q = cq;
		return sym;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			dpd_pkg::REG_MOD: mod_qpsk = val[0];
			dpd_pkg::REG_ALPHA: g_alpha = val;
			dpd_pkg::REG_BETA: g_beta = val;
			dpd_pkg::REG_FUP: f_hi = longint'($signed(val));
			dpd_pkg::REG_FLO: f_lo = longint'($signed(val));
			default: ;
		endcase
	endtask

	task automatic drain();
		while (symbols_due.size() != 0) @(negedge clk);
		repeat (HOLD) @(negedge clk);
	endtask

	task automatic send_sample(int si, int sq, int want, bit gaps);
		logic [1:0] sym;
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {sq[15:0], si[15:0]};
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		sym = demod_step(longint'($signed(si[15:0])), longint'($signed(sq[15:0])));
		symbols_due.push_back(want == NONE ? sym : want[1:0]);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		if (gaps && !calm && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
	endtask

	task automatic random_run(int n);
		int amp, ang, si, sq;
		for (int j = 0; j < n; j++) begin
			if ($urandom_range(0, 4) == 0) begin
				si = $urandom;
				sq = $urandom;
			end else begin
				// noisy constellation point
				amp = $urandom_range(500, 32767);
				ang = $urandom_range(0, 3);
				si = (ang == 0) ? amp : (ang == 2) ? -amp : 0;
				sq = (ang == 1) ? amp : (ang == 3) ? -amp : 0;
				si = int'(sat16(si + $signed($urandom_range(0, 4000)) - 2000));
				sq = int'(sat16(sq + $signed($urandom_range(0, 4000)) - 2000));
			end
			if (j == n / 2 && n > 100) drain();
			send_sample(si, sq, NONE, 1);
		end
	endtask

	always @(negedge clk) begin
		if (calm) begin
			m_axis_tready = 1'b1;
		end else begin
			m_axis_tready = $urandom_range(0, 2) != 0;
			repeat ($urandom_range(1, 18)) begin
				if (!calm) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (symbols_due.size() == 0) begin
				$error("symbol: unexpected item %0d", m_axis_tdata[1:0]);
				errors++;
			end else if (m_axis_tdata[1:0] !== symbols_due[0]) begin
				$error("symbol: expected %0d, got %0d", symbols_due[0], m_axis_tdata[1:0]);
				errors++;
				void'(symbols_due.pop_front());
			end else begin
				void'(symbols_due.pop_front());
			end
		end
	end

	row_t directed[14] = '{
		'{20000, 0, 0}, '{-20000, 0, 1}, '{0, 0, NONE}, '{0, 0, NONE},
		'{32767, 32767, NONE}, '{-32768, -32768, NONE}, '{-32768, 32767, NONE},
		'{32767, -32768, NONE}, '{0, 20000, NONE}, '{0, -20000, NONE},
		'{1, -1, NONE}, '{-1, 1, NONE}, '{21845, -10922, NONE}, '{-32768, 0, NONE}
	};

	initial begin
		mod_qpsk = 0; g_alpha = 2048; g_beta = 64; f_hi = 4096; f_lo = -4096;
		last_i = 32767; last_q = 0; lp_phase = '0; lp_freq = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed[n]) send_sample(directed[n].si, directed[n].sq, directed[n].want, 0);
		random_run(250);
		drain();
		write_reg(dpd_pkg::REG_MOD, 16'd1);
		write_reg(dpd_pkg::REG_ALPHA, 16'hFFFF);
		write_reg(dpd_pkg::REG_BETA, 16'hFFFF);
		write_reg(dpd_pkg::REG_FUP, 16'h7FFF);
		write_reg(dpd_pkg::REG_FLO, 16'h8000);
		foreach (directed[n]) send_sample(directed[n].si, directed[n].sq, NONE, 0);
		random_run(300);
		drain();
		write_reg(dpd_pkg::REG_ALPHA, 16'd0);
		write_reg(dpd_pkg::REG_BETA, 16'd0);
		random_run(250);
		drain();
		// lower clamp above upper clamp
		write_reg(dpd_pkg::REG_MOD, 16'd0);
		write_reg(dpd_pkg::REG_ALPHA, 16'd4096);
		write_reg(dpd_pkg::REG_BETA, 16'd1024);
		write_reg(dpd_pkg::REG_FUP, 16'd100);
		write_reg(dpd_pkg::REG_FLO, 16'd200);
		write_reg(3'd7, 16'hFFFF);
		random_run(300);
		drain();
		write_reg(dpd_pkg::REG_MOD, 16'd1);
		write_reg(dpd_pkg::REG_FUP, 16'h8000);
		write_reg(dpd_pkg::REG_FLO, 16'h7FFF);
		write_reg(dpd_pkg::REG_BETA, 16'd64);
		random_run(300);
		drain();
		write_reg(dpd_pkg::REG_ALPHA, 16'd2048);
		write_reg(dpd_pkg::REG_FUP, 16'd4096);
		write_reg(dpd_pkg::REG_FLO, -16'sd4096);
		random_run(200);
		calm = 1;
		random_run(150);
		while (symbols_due.size() != 0) @(negedge clk);
		repeat (HOLD) @(negedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/dpd_pkg.sv
hw/rtl/dpd_ctrl.sv
hw/rtl/dpd_datapath.sv
hw/rtl/differential_psk_demod_pll.sv
sim/testbench.sv
